[rtl/core/dcb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor chain builder package
// Shared constants, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dcb_pkg;

   // Chain geometry
   localparam int MAX_DESCRIPTORS  = 64;
   localparam int CHUNK_BYTES      = 4096;
   localparam int BLOCK_BYTES      = 512;
   localparam int DESCRIPTOR_BYTES = 16;

   localparam int CHUNK_SHIFT    = $clog2(CHUNK_BYTES);
   localparam int MAX_TRANSFER   = MAX_DESCRIPTORS * CHUNK_BYTES;

   // Field widths
   localparam int ADDR_WIDTH     = 32;
   localparam int XFER_WIDTH     = 19;
   localparam int INDEX_WIDTH    = 6;
   localparam int COUNT_WIDTH    = INDEX_WIDTH + 1;
   localparam int SIZE_WIDTH     = 13;
   localparam int BLOCK_WIDTH    = 10;
   localparam int NEED_WIDTH     = 14;
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TABLE_BASE  = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TABLE_BYTES = 1'd1;

   // Register reset values
   localparam logic [ADDR_WIDTH-1:0] TABLE_BASE_RESET  = '0;
   localparam logic [SIZE_WIDTH-1:0] TABLE_BYTES_RESET = 13'd1024;

   // Control word bits
   localparam logic [31:0] CW_OWN   = 32'h8000_0000;
   localparam logic [31:0] CW_CHAIN = 32'h0000_0010;
   localparam logic [31:0] CW_FIRST = 32'h0000_0008;
   localparam logic [31:0] CW_LAST  = 32'h0000_0004;
   localparam logic [31:0] CW_NOINT = 32'h0000_0002;

   typedef enum logic {
      ST_IDLE,
      ST_EMIT
   } dcb_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic advance;
   } dcb_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last;
   } dcb_status_type;

endpackage
`default_nettype wire

[rtl/core/dma_descriptor_chain_builder_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DMA descriptor chain builder
// Turns one transfer request into its chained list of DMA descriptors.
// ----------------------------------------------------------------------------
// Each accepted request is cut into 4096-byte chunks and yields one
// descriptor per chunk on the rsp channel, index 0 first, with the last one
// flagged by end_of_chain; a zero, oversized or misaligned request, or one
// whose chain does not fit the table, yields a single result with
// request_error set and all other fields zero. A request is accepted in
// the idle state; its descriptors then follow from the datapath's
// descriptor counter, one descriptor per cycle while rsp_ready is held high.
// The next request is taken once the last result of the current one has
// been taken. Write the table registers only while the block is idle.
module dma_descriptor_chain_builder_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dcb_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [dcb_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [dcb_pkg::ADDR_WIDTH-1:0]       req_buffer_address,
   input  wire logic [dcb_pkg::XFER_WIDTH-1:0]       req_transfer_bytes,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [dcb_pkg::INDEX_WIDTH-1:0]           rsp_descriptor_index,
   output logic [31:0]                               rsp_control_word,
   output logic [dcb_pkg::SIZE_WIDTH-1:0]            rsp_chunk_size,
   output logic [dcb_pkg::ADDR_WIDTH-1:0]            rsp_chunk_address,
   output logic [dcb_pkg::ADDR_WIDTH-1:0]            rsp_next_address,
   output logic [dcb_pkg::BLOCK_WIDTH-1:0]           rsp_block_size_value,
   output logic                                      rsp_end_of_chain,
   output logic                                      rsp_request_error
);
   import dcb_pkg::*;

   dcb_cmd_type    cmd;
   dcb_status_type status;

   // Table registers take a write every cycle
   assign csr_ready = 1'b1;

   dcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   dcb_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .csr_write            (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .req_buffer_address   (req_buffer_address),
      .req_transfer_bytes   (req_transfer_bytes),
      .cmd                  (cmd),
      .status               (status),
      .rsp_descriptor_index (rsp_descriptor_index),
      .rsp_control_word     (rsp_control_word),
      .rsp_chunk_size       (rsp_chunk_size),
      .rsp_chunk_address    (rsp_chunk_address),
      .rsp_next_address     (rsp_next_address),
      .rsp_block_size_value (rsp_block_size_value),
      .rsp_end_of_chain     (rsp_end_of_chain),
      .rsp_request_error    (rsp_request_error)
   );

   // A new request is never taken while a result is pending
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request taken while results pending");

   // Every accepted request produces a result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("no result after accepted request");

   // An error result carries nothing else
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_request_error) |->
         (!rsp_end_of_chain && rsp_control_word == '0 && rsp_next_address == '0))
      else $error("error result carries descriptor data");

   // The chain ends after its final result is taken
   a_chain_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && (rsp_end_of_chain || rsp_request_error)) |=> !rsp_valid)
      else $error("results continue past end of chain");

   // Taking a middle descriptor moves to the next index
   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_end_of_chain && !rsp_request_error) |=>
         (rsp_valid && rsp_descriptor_index ==
            INDEX_WIDTH'($past(rsp_descriptor_index) + INDEX_WIDTH'(1))))
      else $error("descriptor index did not advance");

endmodule
`default_nettype wire

[rtl/core/dcb_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor chain builder controller
// Sequences request accept and descriptor emission, one descriptor a cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module dcb_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output dcb_pkg::dcb_cmd_type         cmd,
   input  wire dcb_pkg::dcb_status_type status
);
   import dcb_pkg::*;

   dcb_state_type state_ff;
   dcb_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      cmd.load    = 1'b0;
      cmd.advance = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.advance = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/core/dcb_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Descriptor chain builder datapath
// Table registers, request check and running descriptor fields.
// ----------------------------------------------------------------------------
module dcb_datapath (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_write,
   input  wire logic [dcb_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  wire logic [dcb_pkg::CSR_DATA_WIDTH-1:0]      csr_write_data,
   input  wire logic [dcb_pkg::ADDR_WIDTH-1:0]          req_buffer_address,
   input  wire logic [dcb_pkg::XFER_WIDTH-1:0]          req_transfer_bytes,
   input  wire dcb_pkg::dcb_cmd_type                    cmd,
   output dcb_pkg::dcb_status_type                      status,
   output logic [dcb_pkg::INDEX_WIDTH-1:0]              rsp_descriptor_index,
   output logic [31:0]                                  rsp_control_word,
   output logic [dcb_pkg::SIZE_WIDTH-1:0]               rsp_chunk_size,
   output logic [dcb_pkg::ADDR_WIDTH-1:0]               rsp_chunk_address,
   output logic [dcb_pkg::ADDR_WIDTH-1:0]               rsp_next_address,
   output logic [dcb_pkg::BLOCK_WIDTH-1:0]              rsp_block_size_value,
   output logic                                         rsp_end_of_chain,
   output logic                                         rsp_request_error
);
   import dcb_pkg::*;

   logic [ADDR_WIDTH-1:0]  table_base_ff;
   logic [SIZE_WIDTH-1:0]  table_bytes_ff;

   logic [INDEX_WIDTH-1:0] idx_ff;
   logic [INDEX_WIDTH-1:0] last_idx_ff;
   logic [ADDR_WIDTH-1:0]  addr_ff;
   logic [ADDR_WIDTH-1:0]  next_ff;
   logic [XFER_WIDTH-1:0]  rem_ff;
   logic [BLOCK_WIDTH-1:0] blk_ff;
   logic                   err_ff;

   logic [XFER_WIDTH:0]    round_up;
   logic [COUNT_WIDTH-1:0] count;
   logic [NEED_WIDTH-1:0]  table_need;
   logic [ADDR_WIDTH-1:0]  base;
   logic                   bad_request;
   logic                   last;

   // Table registers
   always_ff @(posedge clock) begin
      if (reset) begin
         table_base_ff  <= TABLE_BASE_RESET;
         table_bytes_ff <= TABLE_BYTES_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_TABLE_BASE:  table_base_ff  <= csr_write_data;
            CSR_TABLE_BYTES: table_bytes_ff <= csr_write_data[SIZE_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Check the request and size its chain
   always_comb begin
      base        = {table_base_ff[ADDR_WIDTH-1:4], 4'h0};
      round_up    = {1'b0, req_transfer_bytes} + (XFER_WIDTH + 1)'(CHUNK_BYTES - 1);
      count       = COUNT_WIDTH'(round_up >> CHUNK_SHIFT);
      table_need  = NEED_WIDTH'(count) * NEED_WIDTH'(DESCRIPTOR_BYTES);
      bad_request = (req_transfer_bytes == '0)
                 || ({1'b0, req_transfer_bytes} > (XFER_WIDTH + 1)'(MAX_TRANSFER))
                 || (req_buffer_address[3:0] != 4'h0)
                 || (table_need > NEED_WIDTH'(table_bytes_ff));
   end

   // Load on accept, advance one descriptor per taken result
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         last_idx_ff <= '0;
         err_ff      <= 1'b0;
      end else if (cmd.load) begin
         idx_ff      <= '0;
         last_idx_ff <= INDEX_WIDTH'(count - COUNT_WIDTH'(1));
         err_ff      <= bad_request;
      end else if (cmd.advance) begin
         idx_ff      <= idx_ff + INDEX_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         addr_ff <= req_buffer_address;
         next_ff <= base + ADDR_WIDTH'(DESCRIPTOR_BYTES);
         rem_ff  <= req_transfer_bytes;
         blk_ff  <= (req_transfer_bytes < XFER_WIDTH'(BLOCK_BYTES))
                  ? BLOCK_WIDTH'(req_transfer_bytes) : BLOCK_WIDTH'(BLOCK_BYTES);
      end else if (cmd.advance) begin
         addr_ff <= addr_ff + ADDR_WIDTH'(CHUNK_BYTES);
         next_ff <= next_ff + ADDR_WIDTH'(DESCRIPTOR_BYTES);
         rem_ff  <= rem_ff - XFER_WIDTH'(CHUNK_BYTES);
      end
   end

   // Form the current descriptor
   always_comb begin
      last          = (idx_ff == last_idx_ff);
      status.last   = err_ff || last;

      rsp_request_error    = err_ff;
      rsp_descriptor_index = '0;
      rsp_control_word     = '0;
      rsp_chunk_size       = '0;
      rsp_chunk_address    = '0;
      rsp_next_address     = '0;
      rsp_block_size_value = '0;
      rsp_end_of_chain     = 1'b0;
      if (!err_ff) begin
         rsp_descriptor_index = idx_ff;
         rsp_control_word     = CW_OWN | (last ? CW_LAST : (CW_CHAIN | CW_NOINT))
                              | ((idx_ff == '0) ? CW_FIRST : '0);
         rsp_chunk_size       = last ? SIZE_WIDTH'(rem_ff) : SIZE_WIDTH'(CHUNK_BYTES);
         rsp_chunk_address    = addr_ff;
         rsp_next_address     = last ? '0 : next_ff;
         rsp_block_size_value = blk_ff;
         rsp_end_of_chain     = last;
      end
   end

endmodule
`default_nettype wire
